[rtl/pool_free_list_allocator_core_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the pool free-list allocator
// Concurrent checks on clk, disabled while rst_n is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef POOL_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH
`define POOL_FREE_LIST_ALLOCATOR_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define PFLA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pool allocator check failed");
// next-cycle implication
`define PFLA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pool allocator check failed");
`else
`define PFLA_ASSERT_IMPL(label, ante, cons)
`define PFLA_ASSERT_NEXT(label, ante, cons)
`endif

`endif

[rtl/pfla_pkg.sv]
// ----------------------------------------------------------------------------
// pfla_pkg
// Widths, codes and shared types of the pool free-list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pfla_pkg;

    localparam int MAX_CHUNKS = 1024;

    // free-list storage
    localparam int IDX_W    = $clog2(MAX_CHUNKS);
    localparam int LINK_W   = IDX_W + 1;
    localparam logic [LINK_W-1:0] LIST_END = LINK_W'(MAX_CHUNKS);

    // request / response fields
    localparam int KIND_W   = 2;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 2;
    localparam int OFFSET_W = 22;

    // configuration registers
    localparam int COUNT_W    = 11;
    localparam int BYTES_W    = 13;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;
    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(1024);
    localparam logic [BYTES_W-1:0] BYTES_RESET = BYTES_W'(64);
    localparam logic [CFG_IDX_W-1:0] REG_POOL_CHUNKS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_BYTES = 1'd1;

    // derived datapath widths
    localparam int CMP_W   = (COUNT_W > LINK_W) ? COUNT_W : LINK_W;
    localparam int PROD_W  = IDX_W + BYTES_W;
    localparam int IDXX_W  = IDX_W + INDEX_W;
    localparam int OFFX_W  = PROD_W + OFFSET_W;

    // request kinds
    localparam logic [KIND_W-1:0] KIND_ALLOC    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_FREE     = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FREE_ALL = 2'd2;

    // response status
    localparam logic [STATUS_W-1:0] STS_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] STS_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] STS_BOUNDS = 2'd2;
    localparam logic [STATUS_W-1:0] STS_NULL   = 2'd3;

    typedef enum logic [1:0] {
        STATE_IDLE,
        STATE_READ,
        STATE_SWEEP,
        STATE_RESP
    } pfla_state_t;

    // controller -> datapath
    typedef struct packed {
        logic take;        // request accepted this cycle
        logic pop;         // link read is back, move head
        logic sweep_step;  // write one link of the free-all sweep
        logic out_load;    // move staged response into output register
    } pfla_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic              head_empty;
        logic              count_zero;
        logic              sweep_last;
    } pfla_sts_t;

endpackage

`default_nettype wire

[rtl/pfla_req_if.sv]
// ----------------------------------------------------------------------------
// pfla_req_if
// Request channel: valid/ready handshake with kind, chunk index and null flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfla_req_if import pfla_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [KIND_W-1:0]  kind;
    logic [INDEX_W-1:0] chunk_index;
    logic               is_null;

    modport source (output valid, output kind, output chunk_index, output is_null,
                    input ready);
    modport sink   (input valid, input kind, input chunk_index, input is_null,
                    output ready);
endinterface

`default_nettype wire

[rtl/pfla_rsp_if.sv]
// ----------------------------------------------------------------------------
// pfla_rsp_if
// Response channel: valid/ready handshake with status, index and byte offset.
// ----------------------------------------------------------------------------
`default_nettype none

interface pfla_rsp_if import pfla_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [INDEX_W-1:0]  granted_index;
    logic [OFFSET_W-1:0] granted_offset;

    modport source (output valid, output status, output granted_index,
                    output granted_offset, input ready);
    modport sink   (input valid, input status, input granted_index,
                    input granted_offset, output ready);
endinterface

`default_nettype wire

[rtl/pfla_ram.sv]
// ----------------------------------------------------------------------------
// pfla_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module pfla_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[rtl/pfla_datapath.sv]
// ----------------------------------------------------------------------------
// pfla_datapath
// Config registers, list head, link memory, sweep counter and response regs.
// ----------------------------------------------------------------------------
`default_nettype none

module pfla_datapath import pfla_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic [KIND_W-1:0]     kind,
    input  logic [INDEX_W-1:0]    chunk_index,
    input  logic                  is_null,
    input  pfla_cmd_t             cmd,
    output pfla_sts_t             sts,
    output logic [STATUS_W-1:0]   status,
    output logic [INDEX_W-1:0]    granted_index,
    output logic [OFFSET_W-1:0]   granted_offset
);

    logic [COUNT_W-1:0]  pool_chunks_reg;
    logic [BYTES_W-1:0]  chunk_bytes_reg;
    logic [LINK_W-1:0]   head_reg, head_next;
    logic [IDX_W-1:0]    sweep_reg, sweep_next;

    logic [STATUS_W-1:0] stg_status_reg, stg_status_next;
    logic [INDEX_W-1:0]  stg_index_reg, stg_index_next;
    logic [OFFSET_W-1:0] stg_offset_reg, stg_offset_next;
    logic [STATUS_W-1:0] out_status_reg;
    logic [INDEX_W-1:0]  out_index_reg;
    logic [OFFSET_W-1:0] out_offset_reg;

    logic [CMP_W-1:0]    count_ext, eff_count, idx_ext, sweep_ext;
    logic                in_bounds, head_empty, sweep_last, free_push;
    logic [IDX_W-1:0]    head_idx;
    logic [PROD_W-1:0]   product;
    logic [IDXX_W-1:0]   idx_wide;
    logic [OFFX_W-1:0]   off_wide;

    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    logic [LINK_W-1:0]   ram_wdata, ram_rdata;

    // ---- configuration ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pool_chunks_reg <= COUNT_RESET;
            chunk_bytes_reg <= BYTES_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_POOL_CHUNKS: pool_chunks_reg <= cfg_wdata[COUNT_W-1:0];
                REG_CHUNK_BYTES: chunk_bytes_reg <= cfg_wdata[BYTES_W-1:0];
                default:         pool_chunks_reg <= pool_chunks_reg;
            endcase
        end
    end

    // ---- derived values ----
    always_comb
    begin
        count_ext  = CMP_W'(pool_chunks_reg);
        eff_count  = (count_ext > CMP_W'(MAX_CHUNKS)) ? CMP_W'(MAX_CHUNKS) : count_ext;
        idx_ext    = CMP_W'(chunk_index);
        in_bounds  = idx_ext < eff_count;
        head_empty = head_reg >= LIST_END;
        head_idx   = head_reg[IDX_W-1:0];
        product    = PROD_W'(head_idx) * PROD_W'(chunk_bytes_reg);
        idx_wide   = IDXX_W'(head_idx);
        off_wide   = OFFX_W'(product);
        sweep_ext  = CMP_W'(sweep_reg);
        sweep_last = sweep_ext == (eff_count - CMP_W'(1));
        free_push  = cmd.take && (kind == KIND_FREE) && !is_null && in_bounds;
    end

    assign sts.kind       = kind;
    assign sts.head_empty = head_empty;
    assign sts.count_zero = eff_count == '0;
    assign sts.sweep_last = sweep_last;

    // ---- link memory ----
    // sweep rebuilds the list bottom-up: link[0] = end, link[i] = i-1
    always_comb
    begin
        ram_we    = free_push || cmd.sweep_step;
        ram_waddr = idx_ext[IDX_W-1:0];
        ram_wdata = head_reg;
        if (cmd.sweep_step)
        begin
            ram_waddr = sweep_reg;
            ram_wdata = (sweep_reg == '0) ? LIST_END
                                          : (LINK_W'(sweep_reg) - LINK_W'(1));
        end
    end

    // read port always follows the head; data is back the cycle after a take
    pfla_ram #(
        .WIDTH (LINK_W),
        .DEPTH (MAX_CHUNKS)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (head_idx),
        .rdata (ram_rdata)
    );

    // ---- head and sweep counter ----
    always_comb
    begin
        head_next  = head_reg;
        sweep_next = sweep_reg;
        if (cmd.take)
        begin
            sweep_next = '0;
            if (free_push)
            begin
                head_next = idx_ext[LINK_W-1:0];
            end
            else if (kind == KIND_FREE_ALL)
            begin
                head_next = LIST_END;
            end
        end
        if (cmd.pop)
        begin
            head_next = ram_rdata;
        end
        if (cmd.sweep_step)
        begin
            sweep_next = sweep_reg + IDX_W'(1);
            if (sweep_last)
            begin
                head_next = LINK_W'(sweep_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= LIST_END;
            sweep_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            sweep_reg <= sweep_next;
        end
    end

    // ---- staged response ----
    always_comb
    begin
        stg_status_next = stg_status_reg;
        stg_index_next  = stg_index_reg;
        stg_offset_next = stg_offset_reg;
        if (cmd.take)
        begin
            stg_status_next = STS_OK;
            stg_index_next  = '0;
            stg_offset_next = '0;
            case (kind)
                KIND_ALLOC:
                begin
                    if (head_empty)
                    begin
                        stg_status_next = STS_EMPTY;
                    end
                    else
                    begin
                        stg_index_next  = idx_wide[INDEX_W-1:0];
                        stg_offset_next = off_wide[OFFSET_W-1:0];
                    end
                end
                KIND_FREE:
                begin
                    if (is_null)
                    begin
                        stg_status_next = STS_NULL;
                    end
                    else if (!in_bounds)
                    begin
                        stg_status_next = STS_BOUNDS;
                    end
                end
                default: stg_status_next = STS_OK;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        stg_status_reg <= stg_status_next;
        stg_index_reg  <= stg_index_next;
        stg_offset_reg <= stg_offset_next;
        if (cmd.out_load)
        begin
            out_status_reg <= stg_status_reg;
            out_index_reg  <= stg_index_reg;
            out_offset_reg <= stg_offset_reg;
        end
    end

    assign status         = out_status_reg;
    assign granted_index  = out_index_reg;
    assign granted_offset = out_offset_reg;

endmodule

`default_nettype wire

[rtl/pfla_ctrl.sv]
// ----------------------------------------------------------------------------
// pfla_ctrl
// Sequencer: accepts one request, steps the datapath, owns output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module pfla_ctrl import pfla_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    input  pfla_sts_t sts,
    output pfla_cmd_t cmd
);

    pfla_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        slot_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= STATE_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output register can take a new response if empty or being drained
    assign slot_free = !out_valid_reg || rsp_ready;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        req_ready      = 1'b0;
        unique case (state_reg)
            STATE_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.take = 1'b1;
                    if ((sts.kind == KIND_ALLOC) && !sts.head_empty)
                    begin
                        state_next = STATE_READ;
                    end
                    else if ((sts.kind == KIND_FREE_ALL) && !sts.count_zero)
                    begin
                        state_next = STATE_SWEEP;
                    end
                    else
                    begin
                        state_next = STATE_RESP;
                    end
                end
            end
            STATE_READ:
            begin
                cmd.pop = 1'b1;
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = STATE_IDLE;
                end
                else
                begin
                    state_next = STATE_RESP;
                end
            end
            STATE_SWEEP:
            begin
                cmd.sweep_step = 1'b1;
                if (sts.sweep_last)
                begin
                    state_next = STATE_RESP;
                end
            end
            STATE_RESP:
            begin
                if (slot_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = STATE_IDLE;
                end
            end
            default: state_next = STATE_IDLE;
        endcase

        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign rsp_valid = out_valid_reg;

endmodule

`default_nettype wire

[rtl/pool_free_list_allocator_core.sv]
// ----------------------------------------------------------------------------
// pool_free_list_allocator_core
// Fixed-size chunk pool kept as a LIFO free list (head register + link RAM).
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request: alloc pops the top chunk, free pushes
//   chunk_index (null and out-of-range requests are answered, list unchanged),
//   free-all rebuilds the list with chunks 0..count-1, count-1 on top.
//   rsp returns exactly one response per request: status, chunk index and
//   byte offset (index * chunk_bytes, truncated to 22 bits).
//   cfg_wr_en/cfg_index/cfg_wdata write the chunk count (0) and chunk_bytes
//   (1); write them only while no request is in flight.
// Timing:
//   alloc passes the read state, where the registered link RAM read returns
//   and the head moves; free writes its link at the accept and, like alloc
//   on an empty list, passes the response state. free-all writes one link per
//   cycle in the sweep state (count saturated at 1024), then the response state.
//   One request is in flight at a time; req.ready is high only when idle.
// Reset:
//   list empty, 1024 chunks of 64 bytes, no response pending.
//   The link RAM is not cleared; only entries written by pushes or sweeps are read.
// Stall:
//   the response register holds while rsp.ready is low; the next request is
//   still accepted and its response waits in a staging register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "pool_free_list_allocator_core_assert.svh"

module pool_free_list_allocator_core import pfla_pkg::*; (
    input  logic                  clk,
    input  logic                  rst_n,
    pfla_req_if.sink              req,
    pfla_rsp_if.source            rsp,
    input  logic                  cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    pfla_cmd_t cmd;
    pfla_sts_t sts;
    logic      grant_zero;

    // sequencer: handshakes and step commands
    pfla_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .rsp_valid (rsp.valid),
        .rsp_ready (rsp.ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    // list state, config, offset multiply and response registers
    pfla_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .kind           (req.kind),
        .chunk_index    (req.chunk_index),
        .is_null        (req.is_null),
        .cmd            (cmd),
        .sts            (sts),
        .status         (rsp.status),
        .granted_index  (rsp.granted_index),
        .granted_offset (rsp.granted_offset)
    );

    // ---- checks ----
    assign grant_zero = (rsp.granted_index == '0) && (rsp.granted_offset == '0);

    // a held response is never overwritten
    `PFLA_ASSERT_IMPL(a_no_overwrite, cmd.out_load && rsp.valid, rsp.ready)
    // one request at a time: no accept right after an accept
    `PFLA_ASSERT_NEXT(a_one_in_flight, req.valid && req.ready, !req.ready)
    // head only moves from the link RAM right after an alloc was taken
    `PFLA_ASSERT_IMPL(a_pop_after_alloc, cmd.pop, $past(cmd.take) && ($past(sts.kind) == KIND_ALLOC))
    // responses without a grant carry zero index and offset
    `PFLA_ASSERT_IMPL(a_no_grant_zero, rsp.valid && (rsp.status != STS_OK), grant_zero)

endmodule

`default_nettype wire

[verif/tb_pool_free_list_allocator_core.sv]
// ----------------------------------------------------------------------------
// tb_pool_free_list_allocator_core
// Self-checking bench for the free-list pool allocator. A scoreboard class
// keeps its own head register and link memory, predicts each grant as its
// request is accepted, and checks every response in order. Directed requests
// cover empty pools, null and out-of-range frees, double frees, shrinking and
// saturating counts and offset truncation. Random phases then usually rebuild the
// pool with free-all and mostly alloc or free chunks that are held, with
// random gaps on both sides, except in one steady phase.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_pool_free_list_allocator_core;
    import pfla_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // No-progress limit: covers a full-pool sweep plus the longest response
    // stall and request gap, several times over.
    localparam int WATCHDOG_LIMIT = 6000;
    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_REQUESTS = 112;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [INDEX_W-1:0]  granted_index;
        logic [OFFSET_W-1:0] granted_offset;
    } grant_t;

    // ------------------------------------------------------------------------
    // Scoreboard: shadow free list plus the queue of grants still owed.
    // ------------------------------------------------------------------------
    class pool_scoreboard;
        logic [LINK_W-1:0]  head;
        logic [LINK_W-1:0]  link [MAX_CHUNKS];
        logic [COUNT_W-1:0] pool_chunks;
        logic [BYTES_W-1:0] chunk_bytes;
        grant_t             owed_grants [$];
        int                 mismatches;
        int                 checked;

        function new();
            head        = LIST_END;
            pool_chunks = COUNT_RESET;
            chunk_bytes = BYTES_RESET;
            mismatches  = 0;
            checked     = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_POOL_CHUNKS)
                pool_chunks = data[COUNT_W-1:0];
            else
                chunk_bytes = data[BYTES_W-1:0];
        endfunction

        // chunk count saturates at the pool size
        function int unsigned usable_chunks();
            int unsigned n;
            n = pool_chunks;
            return (n > MAX_CHUNKS) ? MAX_CHUNKS : n;
        endfunction

        function void push(logic [INDEX_W-1:0] idx);
            link[idx] = head;
            head      = LINK_W'(idx);
        endfunction

        function int pending();
            return owed_grants.size();
        endfunction

        // Accepted request: update the shadow list, queue the grant it owes.
        function grant_t note_request(logic [KIND_W-1:0] kind, logic [INDEX_W-1:0] idx,
                                      logic is_null);
            grant_t            g;
            logic [LINK_W-1:0] top;
            longint unsigned   prod;
            int unsigned       n;
            g = '0;
            case (kind)
                KIND_ALLOC:
                begin
                    if (head >= LIST_END)
                        g.status = STS_EMPTY;
                    else
                    begin
                        top              = head;
                        head             = link[top[IDX_W-1:0]];
                        g.granted_index  = top[INDEX_W-1:0];
                        prod             = 64'(top) * 64'(chunk_bytes);
                        g.granted_offset = prod[OFFSET_W-1:0];
                    end
                end
                KIND_FREE:
                begin
                    if (is_null)
                        g.status = STS_NULL;
                    else if (idx >= usable_chunks())
                        g.status = STS_BOUNDS;
                    else
                        push(idx);
                end
                KIND_FREE_ALL:
                begin
                    n    = usable_chunks();
                    head = LIST_END;
                    for (int unsigned i = 0; i < n; i++)
                        push(INDEX_W'(i));
                end
                default: ;  // unused kind: answered with all zeros
            endcase
            owed_grants.push_back(g);
            return g;
        endfunction

        function void check_response(grant_t got);
            grant_t exp;
            if (owed_grants.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] unexpected response: status %0d index %0d offset %0d",
                             $realtime, got.status, got.granted_index, got.granted_offset);
                return;
            end
            exp = owed_grants.pop_front();
            checked++;
            if (got.status !== exp.status || got.granted_index !== exp.granted_index ||
                got.granted_offset !== exp.granted_offset)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("[%0t] grant %0d: exp %0d/%0d/%0d got %0d/%0d/%0d",
                             $realtime, checked, exp.status, exp.granted_index,
                             exp.granted_offset, got.status, got.granted_index,
                             got.granted_offset);
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, channels, DUT
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    always #1 clk = ~clk;

    pfla_req_if req_ch ();
    pfla_rsp_if rsp_ch ();

    pool_free_list_allocator_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req_ch),
        .rsp       (rsp_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    pool_scoreboard sb;
    logic           steady = 1'b0;   // phase with no gaps on either side
    int             req_total = 0;
    int             cfg_sets = 0;
    int             sweeps = 0;
    int             stall_cycles = 0;
    int             held [$];        // chunks granted and not yet freed

    // Gap length: mostly none, some short, a few long.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Response side: random ready with short and occasional long stalls.
    // ------------------------------------------------------------------------
    initial
    begin
        int ready_hold;
        ready_hold   = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (ready_hold > 0)
                ready_hold--;
            else if (steady || $urandom_range(0, 99) < 70)
            begin
                rsp_ch.ready <= 1'b1;
                ready_hold = $urandom_range(0, 5);
            end
            else
            begin
                rsp_ch.ready <= 1'b0;
                ready_hold = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 2)
                                                          : $urandom_range(8, 40);
            end
        end
    end

    // Response monitor: values sampled at the edge are the pre-edge ones.
    always @(posedge clk)
    begin
        grant_t seen;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            seen.status         = rsp_ch.status;
            seen.granted_index  = rsp_ch.granted_index;
            seen.granted_offset = rsp_ch.granted_offset;
            sb.check_response(seen);
        end
    end

    // Watchdog: ends the run when no request or response moves for too long.
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------------

    // One request. Valid stays high across back-to-back requests; it is only
    // dropped for a gap or a drain, so it never sees two assignments in one step.
    task automatic send_request(input logic [KIND_W-1:0] kind,
                                input logic [INDEX_W-1:0] idx, input logic is_null);
        int     gap;
        grant_t g;
        gap = pick_gap();
        if (gap > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.kind        <= kind;
        req_ch.chunk_index <= idx;
        req_ch.is_null     <= is_null;
        do
            @(posedge clk);
        while (!req_ch.ready);
        g = sb.note_request(kind, idx, is_null);
        req_total++;
        if (kind == KIND_ALLOC && g.status == STS_OK)
            held.push_back(g.granted_index);
        if (kind == KIND_FREE_ALL)
        begin
            held.delete();
            sweeps++;
        end
    endtask

    // Stop sending and wait for every owed grant; a short settle follows.
    task automatic drain_grants();
        req_ch.valid <= 1'b0;
        while (sb.pending() > 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Register write; only called with nothing in flight.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        sb.write_reg(idx, data);
        cfg_sets++;
    endtask

    // Count write with junk in the unused upper data bits.
    task automatic set_count(input int unsigned n);
        write_reg(REG_POOL_CHUNKS, {2'($urandom), 11'(n)});
    endtask

    task automatic set_bytes(input int unsigned n);
        write_reg(REG_CHUNK_BYTES, 13'(n));
    endtask

    // Count mostly small so sweeps stay short; extremes now and then.
    function automatic int unsigned pick_count();
        int r;
        r = $urandom_range(0, 19);
        case (r)
            0:       return 0;
            1:       return 1;
            2:       return 1024;
            3:       return 2047;
            4:       return $urandom_range(0, 2047);
            default: return $urandom_range(2, 24);
        endcase
    endfunction

    function automatic int unsigned pick_bytes();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return 8;
            1:       return 4096;
            2:       return 8191;
            3:       return 0;
            4:       return $urandom_range(0, 8191);
            default: return 8 * $urandom_range(1, 64);
        endcase
    endfunction

    // Mostly well-formed traffic: allocs and frees of held chunks. The rest
    // is random or out-of-range frees, nulls, sweeps and the unused kind.
    task automatic random_request();
        int                  r;
        int                  k;
        int unsigned         n;
        logic [INDEX_W-1:0]  idx;
        logic                is_null;
        r       = $urandom_range(0, 99);
        idx     = INDEX_W'($urandom);
        is_null = $urandom_range(0, 1);
        n       = sb.usable_chunks();
        if (r < 42)
            send_request(KIND_ALLOC, idx, is_null);
        else if (r < 70 && held.size() > 0)
        begin
            k   = $urandom_range(0, held.size() - 1);
            idx = INDEX_W'(held[k]);
            held.delete(k);
            send_request(KIND_FREE, idx, 1'b0);
        end
        else if (r < 84)
        begin
            k = $urandom_range(0, n + 2);
            idx = (k > 1023) ? INDEX_W'(1023) : INDEX_W'(k);
            send_request(KIND_FREE, idx, 1'b0);
        end
        else if (r < 89)
            send_request(KIND_FREE, idx, 1'b1);
        else if (r < 93)
            send_request(KIND_FREE, idx, 1'b0);
        else if (r < 96)
            send_request(KIND_FREE_ALL, idx, is_null);
        else
            send_request(KIND_FREE_ALL + KIND_FREE, idx, is_null);  // unused kind
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb                 = new();
        req_ch.valid       = 1'b0;
        req_ch.kind        = KIND_ALLOC;
        req_ch.chunk_index = '0;
        req_ch.is_null     = 1'b0;
        cfg_wr_en          = 1'b0;
        cfg_index          = REG_POOL_CHUNKS;
        cfg_wdata          = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Reset settings, 1024 chunks of 64 bytes, list empty
        send_request(KIND_ALLOC, 10'd0, 1'b0);              // empty pool
        send_request(KIND_FREE, 10'd1023, 1'b1);            // null free
        send_request(KIND_FREE, 10'd1023, 1'b0);            // top index fits
        send_request(KIND_FREE, 10'd0, 1'b0);
        send_request(KIND_ALLOC, 10'd1023, 1'b1);           // pops 0
        send_request(KIND_ALLOC, 10'd0, 1'b0);              // pops 1023
        send_request(KIND_ALLOC, 10'd0, 1'b0);              // empty again
        send_request(KIND_FREE_ALL + KIND_FREE, 10'd1023, 1'b1);  // unused kind
        drain_grants();

        // Five chunks, largest chunk size
        set_count(5);
        set_bytes(8191);
        send_request(KIND_FREE_ALL, 10'd0, 1'b0);
        send_request(KIND_ALLOC, 10'd0, 1'b0);              // chunk 4
        send_request(KIND_FREE, 10'd1000, 1'b1);            // null beats bounds
        send_request(KIND_FREE, 10'd5, 1'b0);               // end index rejected
        send_request(KIND_FREE, 10'd1023, 1'b0);
        send_request(KIND_FREE, 10'd4, 1'b0);
        send_request(KIND_FREE, 10'd4, 1'b0);               // double free
        send_request(KIND_ALLOC, 10'd0, 1'b0);
        send_request(KIND_ALLOC, 10'd0, 1'b0);
        send_request(KIND_ALLOC, 10'd0, 1'b0);
        drain_grants();

        // Shrink: listed chunks above the new count stay on the list
        set_count(2);
        send_request(KIND_ALLOC, 10'd0, 1'b0);
        send_request(KIND_FREE, 10'd3, 1'b0);
        drain_grants();

        // Zero count: sweep leaves the list empty, every free rejected
        set_count(0);
        send_request(KIND_FREE, 10'd0, 1'b0);
        send_request(KIND_FREE_ALL, 10'd0, 1'b0);
        send_request(KIND_ALLOC, 10'd0, 1'b0);
        drain_grants();

        // Count beyond the pool saturates; zero byte size
        set_count(2047);
        set_bytes(0);
        send_request(KIND_FREE_ALL, 10'd0, 1'b0);
        send_request(KIND_ALLOC, 10'd0, 1'b0);
        send_request(KIND_FREE, 10'd1023, 1'b0);
        drain_grants();

        // Largest in-range offset, then a truncated one
        set_count(1024);
        set_bytes(4096);
        send_request(KIND_ALLOC, 10'd0, 1'b0);
        send_request(KIND_ALLOC, 10'd0, 1'b0);
        drain_grants();
        set_bytes(8191);
        send_request(KIND_ALLOC, 10'd0, 1'b0);
        drain_grants();

        // Random phases, each with fresh settings and a drained pipe after
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            steady = (p == 3);
            set_count(pick_count());
            set_bytes(pick_bytes());
            if ($urandom_range(0, 9) < 8)
                send_request(KIND_FREE_ALL, INDEX_W'($urandom), 1'($urandom));
            for (int i = 0; i < PHASE_REQUESTS; i++)
                random_request();
            drain_grants();
        end
        steady = 1'b0;

        // Tail: let any stray response show up before the verdict
        repeat (16) @(posedge clk);

        $display("covered %0d requests with %0d free-all sweeps over %0d register writes",
                 req_total, sweeps, cfg_sets);
        $display("checked %0d grants, %0d mismatches, %0d still owed",
                 sb.checked, sb.mismatches, sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

[pool_free_list_allocator_core.f]
+incdir+rtl
rtl/pfla_pkg.sv
rtl/pfla_req_if.sv
rtl/pfla_rsp_if.sv
rtl/pfla_ram.sv
rtl/pfla_datapath.sv
rtl/pfla_ctrl.sv
rtl/pool_free_list_allocator_core.sv
verif/tb_pool_free_list_allocator_core.sv
